[rtl/scaled_blit_fill_engine_top_assert.svh]
// ----------------------------------------------------------------------------
// scaled blit and fill engine assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SCALED_BLIT_FILL_ENGINE_TOP_ASSERT_SVH
`define SCALED_BLIT_FILL_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SBFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbfe check failed");

// next-cycle implication, disabled while reset is low
`define SBFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbfe check failed");

`endif

[rtl/sbfe_pkg.sv]
// ----------------------------------------------------------------------------
// sbfe_pkg
// widths, codes, reset values and the controller command bundle
// ----------------------------------------------------------------------------
package sbfe_pkg;

    // source store geometry
    localparam int SOURCE_DEPTH = 4096;
    localparam int SRC_AW       = $clog2(SOURCE_DEPTH);
    localparam int LP_W         = $clog2(SOURCE_DEPTH + 1);

    // field widths
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 14;
    localparam int PITCH_W   = 14;
    localparam int PIX_W     = 32;
    localparam int ADDR_W    = 25;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;

    // one divider step per quotient bit
    localparam int DIV_CNT_W = $clog2(DIM_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST     = 14'd1024;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_BLIT = 2'd1,
        OP_FILL = 2'd2,
        OP_STEP = 2'd3
    } t_op;

    // controller to datapath commands
    typedef struct packed {
        logic load_wr;
        logic start_blit;
        logic start_fill;
        logic div_step;
        logic row_mul;
        logic calc;
        logic out_load;
    } t_dp_cmd;

endpackage

[rtl/sbfe_ram.sv]
// ----------------------------------------------------------------------------
// sbfe_ram
// single-port ram with registered read data and read enable
// ----------------------------------------------------------------------------
module sbfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and held read register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sbfe_ctrl.sv]
// ----------------------------------------------------------------------------
// sbfe_ctrl
// sequencer: input acceptance, divider timing, step pipeline, output valid
// ----------------------------------------------------------------------------
module sbfe_ctrl
    import sbfe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_in_stall,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_CALC,
        S_WB
    } t_state;

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  out_free;
    logic                  accept;

    // next state, commands and handshake
    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        o_in_stall  = !((r_state == S_IDLE) || ((r_state == S_WB) && out_free));
        accept      = i_in_valid && !o_in_stall;
        o_cmd       = '0;
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;

        o_cmd.out_load = (r_state == S_WB) && out_free;
        n_out_valid    = o_cmd.out_load || (r_out_valid && i_out_stall);

        case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIM_W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.row_mul = 1'b1;
                n_state       = S_IDLE;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new transaction overrides the return to idle
        if (accept) begin
            case (t_op'(i_op))
                OP_LOAD: begin
                    o_cmd.load_wr = 1'b1;
                    n_state       = S_IDLE;
                end
                OP_BLIT: begin
                    o_cmd.start_blit = 1'b1;
                    n_state          = S_DIV;
                    n_div_cnt        = '0;
                end
                OP_FILL: begin
                    o_cmd.start_fill = 1'b1;
                    n_state          = S_IDLE;
                end
                OP_STEP: begin
                    n_state = S_CALC;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/sbfe_dp.sv]
// ----------------------------------------------------------------------------
// sbfe_dp
// datapath: registers, source store, scale accumulators, address and colour
// ----------------------------------------------------------------------------
module sbfe_dp
    import sbfe_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic [PIX_W-1:0]          i_pixel,
    input  logic signed [COORD_W-1:0] i_dest_x,
    input  logic signed [COORD_W-1:0] i_dest_y,
    input  logic [DIM_W-1:0]          i_dest_w,
    input  logic [DIM_W-1:0]          i_dest_h,
    input  logic [DIM_W-1:0]          i_src_w,
    input  logic [DIM_W-1:0]          i_src_h,
    output logic [ADDR_W-1:0]         o_word_address,
    output logic [PIX_W-1:0]          o_color,
    output logic                      o_write_enable,
    output logic                      o_last,
    output logic                      o_idle
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BLIT,
        MODE_FILL
    } t_mode;

    // visible span of a rectangle edge against a screen edge
    function automatic logic [DIM_W-1:0] clip_span(
        input logic signed [COORD_W-1:0] start,
        input logic [DIM_W-1:0]          len,
        input logic [DIM_W-1:0]          edge_pos
    );
        logic signed [COORD_W+1:0] room;
        room = $signed({3'b000, edge_pos}) - $signed({{2{start[COORD_W-1]}}, start});
        if (room <= 0) begin
            return '0;
        end else if ({2'b00, len} < $unsigned(room[COORD_W:0])) begin
            return len;
        end else begin
            return room[DIM_W-1:0];
        end
    endfunction

    // one restoring division step, returns {remainder, quotient}
    function automatic logic [2*DIM_W-1:0] div_step(
        input logic [DIM_W-1:0] rem,
        input logic [DIM_W-1:0] quo,
        input logic [DIM_W-1:0] dvs
    );
        logic [DIM_W:0]   shifted;
        logic [DIM_W+1:0] trial;
        shifted = {rem, quo[DIM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs};
        if (!trial[DIM_W+1]) begin
            return {trial[DIM_W-1:0], quo[DIM_W-2:0], 1'b1};
        end else begin
            return {shifted[DIM_W-1:0], quo[DIM_W-2:0], 1'b0};
        end
    endfunction

    // configuration
    logic [DIM_W-1:0]          r_scr_w, r_scr_h;
    logic [PITCH_W-1:0]        r_pitch;
    // operation state
    t_mode                     r_mode;
    logic [LP_W-1:0]           r_ptr;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic [DIM_W-1:0]          r_dw, r_dh, r_sw;
    logic [DIM_W-1:0]          r_cols, r_rows;
    logic [PIX_W-1:0]          r_fill;
    logic [DIM_W-1:0]          r_i, r_j;
    // scale accumulators and divider
    logic [DIM_W-1:0]          r_sx, r_rx, r_ry;
    logic [SRC_AW-1:0]         r_row_base, r_row_step;
    logic [DIM_W-1:0]          r_qw, r_rw, r_qh, r_rh;
    // step stage and output registers
    logic [ADDR_W-1:0]         r_s_addr, r_o_addr;
    logic                      r_s_we, r_s_last, r_s_idle, r_s_fill;
    logic [PIX_W-1:0]          r_o_color;
    logic                      r_o_we, r_o_last, r_o_idle;

    logic [DIM_W-1:0]          n_cols, n_rows;
    logic [2*DIM_W-1:0]        src_area;
    logic                      n_empty;
    logic [2*DIM_W-1:0]        div_w, div_h;
    logic [2*DIM_W-1:0]        row_prod;
    logic signed [COORD_W:0]   col_pos, row_pos;
    logic                      pos_ok;
    logic [DIM_W+PITCH_W-1:0]  addr_prod;
    logic [ADDR_W-1:0]         addr_sum;
    logic [DIM_W-1:0]          i_inc, j_inc;
    logic                      col_end, row_end, last_pos;
    logic [DIM_W:0]            rx_sum, ry_sum;
    logic                      rx_wrap, ry_wrap;
    logic [DIM_W-1:0]          n_rx, n_ry, n_sx;
    logic [SRC_AW-1:0]         n_row_base;
    logic                      store_we;
    logic [SRC_AW-1:0]         rd_idx, ram_addr;
    logic [PIX_W-1:0]          ram_rdata;

    // start decode: visible spans and empty operation
    always_comb begin
        n_cols   = clip_span(i_dest_x, i_dest_w, r_scr_w);
        n_rows   = clip_span(i_dest_y, i_dest_h, r_scr_h);
        src_area = i_src_w * i_src_h;
        n_empty  = (n_cols == '0) || (n_rows == '0);
        if (i_cmd.start_blit && ((i_src_w == '0) || (i_src_h == '0) ||
                (src_area > (2*DIM_W)'(SOURCE_DEPTH)))) begin
            n_empty = 1'b1;
        end
    end

    // divider steps and row stride product
    assign div_w    = div_step(r_rw, r_qw, r_dw);
    assign div_h    = div_step(r_rh, r_qh, r_dh);
    assign row_prod = r_qh * r_sw;

    // position, address and end-of-span flags
    always_comb begin
        col_pos   = $signed({r_x[COORD_W-1], r_x}) + $signed({2'b00, r_i});
        row_pos   = $signed({r_y[COORD_W-1], r_y}) + $signed({2'b00, r_j});
        pos_ok    = !col_pos[COORD_W] && !row_pos[COORD_W];
        addr_prod = row_pos[DIM_W-1:0] * r_pitch;
        addr_sum  = addr_prod[ADDR_W-1:0] + ADDR_W'(col_pos[DIM_W-1:0]);
        i_inc     = r_i + DIM_W'(1);
        j_inc     = r_j + DIM_W'(1);
        col_end   = (i_inc == r_cols);
        row_end   = (j_inc == r_rows);
        last_pos  = col_end && row_end;
    end

    // nearest-neighbour accumulators: quotient plus remainder carry
    always_comb begin
        rx_sum     = {1'b0, r_rx} + {1'b0, r_rw};
        rx_wrap    = (rx_sum >= {1'b0, r_dw});
        n_rx       = rx_wrap ? DIM_W'(rx_sum - {1'b0, r_dw}) : rx_sum[DIM_W-1:0];
        n_sx       = r_sx + r_qw + DIM_W'(rx_wrap);
        ry_sum     = {1'b0, r_ry} + {1'b0, r_rh};
        ry_wrap    = (ry_sum >= {1'b0, r_dh});
        n_ry       = ry_wrap ? DIM_W'(ry_sum - {1'b0, r_dh}) : ry_sum[DIM_W-1:0];
        n_row_base = r_row_base + r_row_step + (ry_wrap ? SRC_AW'(r_sw) : '0);
    end

    // source store port: loads write, steps read
    assign store_we = i_cmd.load_wr && (r_ptr < LP_W'(SOURCE_DEPTH));
    assign rd_idx   = r_row_base + SRC_AW'(r_sx);
    assign ram_addr = i_cmd.calc ? rd_idx : r_ptr[SRC_AW-1:0];

    sbfe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SOURCE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_re    (i_cmd.calc),
        .i_addr  (ram_addr),
        .i_wdata (i_pixel),
        .o_rdata (ram_rdata)
    );

    // control state: configuration, mode, load pointer, position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCREEN_WIDTH_RST;
            r_scr_h <= SCREEN_HEIGHT_RST;
            r_pitch <= ROW_PITCH_RST;
            r_mode  <= MODE_IDLE;
            r_ptr   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data[DIM_W-1:0];
                    CFG_ROW_PITCH:     r_pitch <= i_cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end
            if (store_we) begin
                r_ptr <= r_ptr + LP_W'(1);
            end
            if (i_cmd.start_blit || i_cmd.start_fill) begin
                r_ptr <= '0;
                r_i   <= '0;
                r_j   <= '0;
                if (n_empty) begin
                    r_mode <= MODE_IDLE;
                end else begin
                    r_mode <= i_cmd.start_blit ? MODE_BLIT : MODE_FILL;
                end
            end else if (i_cmd.calc && (r_mode != MODE_IDLE)) begin
                if (last_pos) begin
                    r_mode <= MODE_IDLE;
                    r_i    <= '0;
                    r_j    <= '0;
                end else if (col_end) begin
                    r_i <= '0;
                    r_j <= j_inc;
                end else begin
                    r_i <= i_inc;
                end
            end
        end
    end

    // operation payload, scale state, step stage and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_blit || i_cmd.start_fill) begin
            r_x        <= i_dest_x;
            r_y        <= i_dest_y;
            r_dw       <= i_dest_w;
            r_dh       <= i_dest_h;
            r_cols     <= n_cols;
            r_rows     <= n_rows;
            r_sx       <= '0;
            r_rx       <= '0;
            r_ry       <= '0;
            r_row_base <= '0;
        end else if (i_cmd.calc && (r_mode != MODE_IDLE) && !last_pos) begin
            if (col_end) begin
                r_sx       <= '0;
                r_rx       <= '0;
                r_ry       <= n_ry;
                r_row_base <= n_row_base;
            end else begin
                r_sx <= n_sx;
                r_rx <= n_rx;
            end
        end
        if (i_cmd.start_fill) begin
            r_fill <= i_pixel;
        end
        // source scale ratios by restoring division
        if (i_cmd.start_blit) begin
            r_sw <= i_src_w;
            r_qw <= i_src_w;
            r_rw <= '0;
            r_qh <= i_src_h;
            r_rh <= '0;
        end else if (i_cmd.div_step) begin
            {r_rw, r_qw} <= div_w;
            {r_rh, r_qh} <= div_h;
        end
        if (i_cmd.row_mul) begin
            r_row_step <= row_prod[SRC_AW-1:0];
        end
        if (i_cmd.calc) begin
            r_s_addr <= addr_sum;
            r_s_idle <= (r_mode == MODE_IDLE);
            r_s_we   <= (r_mode != MODE_IDLE) && pos_ok;
            r_s_last <= (r_mode != MODE_IDLE) && last_pos;
            r_s_fill <= (r_mode == MODE_FILL);
        end
        if (i_cmd.out_load) begin
            r_o_idle  <= r_s_idle;
            r_o_we    <= r_s_we;
            r_o_last  <= r_s_last;
            r_o_addr  <= r_s_we ? r_s_addr : '0;
            r_o_color <= r_s_we ? (r_s_fill ? r_fill : ram_rdata) : '0;
        end
    end

    assign o_word_address = r_o_addr;
    assign o_color        = r_o_color;
    assign o_write_enable = r_o_we;
    assign o_last         = r_o_last;
    assign o_idle         = r_o_idle;

endmodule

[rtl/scaled_blit_fill_engine_top.sv]
// ----------------------------------------------------------------------------
// scaled_blit_fill_engine_top
// nearest-neighbour scaling blit and rectangle fill, one position per step
// ----------------------------------------------------------------------------
// Transactions are op codes: load a source pixel, start a blit, start a fill,
// or step to the next destination position. Load and start fill need no
// further states. Start blit computes the width and height scale ratios in
// two parallel restoring dividers that each retire one quotient bit per cycle,
// followed by the row stride product. A step forms the framebuffer address
// and reads the source store in its calc state (one single-port memory, so a
// load and a read never share a cycle), then writes the output register once
// that register is free. The next transaction is taken while a result
// still waits in the output register; the source store needs no clearing pass
// after reset.
module scaled_blit_fill_engine_top
    import sbfe_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_op,
    input  logic [PIX_W-1:0]          i_pixel,
    input  logic signed [COORD_W-1:0] i_dest_x,
    input  logic signed [COORD_W-1:0] i_dest_y,
    input  logic [DIM_W-1:0]          i_dest_w,
    input  logic [DIM_W-1:0]          i_dest_h,
    input  logic [DIM_W-1:0]          i_src_w,
    input  logic [DIM_W-1:0]          i_src_h,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [ADDR_W-1:0]         o_word_address,
    output logic [PIX_W-1:0]          o_color,
    output logic                      o_write_enable,
    output logic                      o_last,
    output logic                      o_idle
);

    t_dp_cmd cmd;

    // sequencer
    sbfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath
    sbfe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel        (i_pixel),
        .i_dest_x       (i_dest_x),
        .i_dest_y       (i_dest_y),
        .i_dest_w       (i_dest_w),
        .i_dest_h       (i_dest_h),
        .i_src_w        (i_src_w),
        .i_src_h        (i_src_h),
        .o_word_address (o_word_address),
        .o_color        (o_color),
        .o_write_enable (o_write_enable),
        .o_last         (o_last),
        .o_idle         (o_idle)
    );

endmodule

[rtl/sbfe_checker.sv]
// ----------------------------------------------------------------------------
// sbfe_checker
// port-level checks on result fields and step latency, bound to the top level
// ----------------------------------------------------------------------------
`include "scaled_blit_fill_engine_top_assert.svh"

module sbfe_checker
    import sbfe_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic [OP_W-1:0]           i_op,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [ADDR_W-1:0]         o_word_address,
    input logic [PIX_W-1:0]          o_color,
    input logic                      o_write_enable,
    input logic                      o_last,
    input logic                      o_idle
);

    // an idle report carries nothing else
    `SBFE_ASSERT_IMP(a_idle_clean, i_clk, i_rst_n, o_out_valid && o_idle, !o_write_enable && !o_last && (o_word_address == '0) && (o_color == '0))

    // a clipped position has zero address and colour
    `SBFE_ASSERT_IMP(a_clip_zero, i_clk, i_rst_n, o_out_valid && !o_write_enable, (o_word_address == '0) && (o_color == '0))

    // output valid is always high once a step transaction has passed its calc and write-back states
    `SBFE_ASSERT_IMP(a_step_latency, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_op == OP_STEP), ##3 o_out_valid)

    // a stalled result holds
    `SBFE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_word_address) && $stable(o_color) && $stable(o_write_enable) && $stable(o_last) && $stable(o_idle))

endmodule

bind scaled_blit_fill_engine_top sbfe_checker u_sbfe_checker (.*);

[dv/scaled_blit_fill_engine_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_blit_fill_engine_checker
// watches the config port and both channels, works out the position, address
// and colour of every step from its own copy of the engine state, and
// compares each output transaction against the oldest pending expectation
// ----------------------------------------------------------------------------
module scaled_blit_fill_engine_checker
    import sbfe_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [OP_W-1:0]           i_op,
    input  logic [PIX_W-1:0]          i_pixel,
    input  logic signed [COORD_W-1:0] i_dest_x,
    input  logic signed [COORD_W-1:0] i_dest_y,
    input  logic [DIM_W-1:0]          i_dest_w,
    input  logic [DIM_W-1:0]          i_dest_h,
    input  logic [DIM_W-1:0]          i_src_w,
    input  logic [DIM_W-1:0]          i_src_h,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [ADDR_W-1:0]         i_word_address,
    input  logic [PIX_W-1:0]          i_color,
    input  logic                      i_write_enable,
    input  logic                      i_last,
    input  logic                      i_idle,
    output int                        o_mismatch_count,
    output int                        o_outstanding
);

    typedef enum logic [1:0] {
        ENGINE_IDLE,
        ENGINE_BLIT,
        ENGINE_FILL
    } t_engine_mode;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic [PIX_W-1:0]  color;
        logic              write_enable;
        logic              last;
        logic              idle;
    } t_pixel_write;

    // engine state as seen from the ports
    logic [PIX_W-1:0] source_pixels [SOURCE_DEPTH];
    int unsigned      load_ptr;
    t_engine_mode     mode;
    int unsigned      row_idx, col_idx;
    int               rect_x, rect_y;
    int unsigned      rect_w, rect_h;
    int unsigned      rows_visit, cols_visit;
    int unsigned      src_w, src_h;
    logic [PIX_W-1:0] fill_colour;
    int unsigned      screen_w, screen_h, pitch_words;

    t_pixel_write     expected_writes[$];
    int               mismatches;

    // span of a rectangle side that lies before the clip edge
    function automatic int unsigned visible_span(int start, int unsigned len,
                                                 int unsigned edge_pos);
        int room;
        room = int'(edge_pos) - start;
        if (room <= 0) return 0;
        return (len < unsigned'(room)) ? len : unsigned'(room);
    endfunction

    // one accepted input transaction: update state, queue the step result
    task automatic predict_pixel_write();
        t_pixel_write want;
        int           col, row;
        int unsigned  src_row, src_col, src_idx;
        longint       addr;
        logic         at_end;
        case (t_op'(i_op))
            OP_LOAD: begin
                // loads past the end of the store are dropped
                if (load_ptr < SOURCE_DEPTH) begin
                    source_pixels[load_ptr] = i_pixel;
                    load_ptr++;
                end
            end
            OP_BLIT, OP_FILL: begin
                load_ptr = 0;
                rect_x   = int'(i_dest_x);
                rect_y   = int'(i_dest_y);
                rect_w   = i_dest_w;
                rect_h   = i_dest_h;
                src_w    = i_src_w;
                src_h    = i_src_h;
                if (t_op'(i_op) == OP_FILL) fill_colour = i_pixel;
                cols_visit = visible_span(rect_x, rect_w, screen_w);
                rows_visit = visible_span(rect_y, rect_h, screen_h);
                row_idx    = 0;
                col_idx    = 0;
                mode = (t_op'(i_op) == OP_BLIT) ? ENGINE_BLIT : ENGINE_FILL;
                // nothing visible, or an unusable source, leaves it idle
                if (cols_visit == 0 || rows_visit == 0) mode = ENGINE_IDLE;
                if (t_op'(i_op) == OP_BLIT &&
                    (src_w == 0 || src_h == 0 || src_w * src_h > SOURCE_DEPTH))
                    mode = ENGINE_IDLE;
            end
            default: begin
                want = '0;
                if (mode == ENGINE_IDLE) begin
                    want.idle = 1'b1;
                end else begin
                    col    = rect_x + int'(col_idx);
                    row    = rect_y + int'(row_idx);
                    at_end = (col_idx + 1 == cols_visit) && (row_idx + 1 == rows_visit);
                    // negative row or column: visited but not written
                    if (col >= 0 && row >= 0) begin
                        addr = longint'(row) * longint'(pitch_words) + longint'(col);
                        want.word_address = addr[ADDR_W-1:0];
                        want.write_enable = 1'b1;
                        if (mode == ENGINE_BLIT) begin
                            // nearest-neighbour source position
                            src_row = (row_idx * src_h) / rect_h;
                            src_col = (col_idx * src_w) / rect_w;
                            src_idx = src_row * src_w + src_col;
                            want.color = (src_idx < SOURCE_DEPTH) ?
                                         source_pixels[src_idx] : '0;
                        end else begin
                            want.color = fill_colour;
                        end
                    end
                    want.last = at_end;
                    // advance row by row
                    if (at_end) begin
                        mode    = ENGINE_IDLE;
                        row_idx = 0;
                        col_idx = 0;
                    end else if (col_idx + 1 == cols_visit) begin
                        col_idx = 0;
                        row_idx++;
                    end else begin
                        col_idx++;
                    end
                end
                expected_writes.push_back(want);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_pixel_write seen, want;
        if (!i_rst_n) begin
            load_ptr    = 0;
            mode        = ENGINE_IDLE;
            row_idx     = 0;
            col_idx     = 0;
            rect_x      = 0;
            rect_y      = 0;
            rect_w      = 0;
            rect_h      = 0;
            rows_visit  = 0;
            cols_visit  = 0;
            src_w       = 0;
            src_h       = 0;
            fill_colour = '0;
            screen_w    = SCREEN_WIDTH_RST;
            screen_h    = SCREEN_HEIGHT_RST;
            pitch_words = ROW_PITCH_RST;
            mismatches  = 0;
            expected_writes.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  screen_w    = i_cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: screen_h    = i_cfg_data[DIM_W-1:0];
                    CFG_ROW_PITCH:     pitch_words = i_cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end
            // output transaction against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_word_address, i_color, i_write_enable, i_last, i_idle};
                if (expected_writes.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result addr=%h color=%h we=%b last=%b idle=%b",
                                 $realtime, seen.word_address, seen.color,
                                 seen.write_enable, seen.last, seen.idle);
                    mismatches++;
                end else begin
                    want = expected_writes.pop_front();
                    if (seen !== want) begin
                        if (mismatches < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected addr=%h color=%h we=%b last=%b idle=%b",
                                     want.word_address, want.color,
                                     want.write_enable, want.last, want.idle);
                            $display("  actual   addr=%h color=%h we=%b last=%b idle=%b",
                                     seen.word_address, seen.color,
                                     seen.write_enable, seen.last, seen.idle);
                        end
                        mismatches++;
                    end
                end
            end
            // input transaction
            if (i_in_valid && !i_in_stall) predict_pixel_write();
        end
        o_outstanding    <= expected_writes.size();
        o_mismatch_count <= mismatches;
    end

endmodule

[dv/scaled_blit_fill_engine_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_blit_fill_engine_top_tb
// drives op transactions and register writes into the blit and fill engine
// under random back-pressure on both sides and gives the pass or fail verdict
// ----------------------------------------------------------------------------
module scaled_blit_fill_engine_top_tb;
    import sbfe_pkg::*;

    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRIME_LOADS    = 64;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic [OP_W-1:0]           i_op        = '0;
    logic [PIX_W-1:0]          i_pixel     = '0;
    logic signed [COORD_W-1:0] i_dest_x    = '0;
    logic signed [COORD_W-1:0] i_dest_y    = '0;
    logic [DIM_W-1:0]          i_dest_w    = '0;
    logic [DIM_W-1:0]          i_dest_h    = '0;
    logic [DIM_W-1:0]          i_src_w     = '0;
    logic [DIM_W-1:0]          i_src_h     = '0;
    logic                      i_out_stall = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [ADDR_W-1:0]         o_word_address;
    logic [PIX_W-1:0]          o_color;
    logic                      o_write_enable;
    logic                      o_last;
    logic                      o_idle;

    int mismatch_count;
    int outstanding;

    // stimulus knobs
    int   tx_idle_pct  = 36;
    int   rx_idle_pct  = 78;
    int   screen_w     = SCREEN_WIDTH_RST;
    int   screen_h     = SCREEN_HEIGHT_RST;
    int   items_sent   = 0;
    logic hold_request = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   idle_cycles  = 0;

    scaled_blit_fill_engine_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_pixel        (i_pixel),
        .i_dest_x       (i_dest_x),
        .i_dest_y       (i_dest_y),
        .i_dest_w       (i_dest_w),
        .i_dest_h       (i_dest_h),
        .i_src_w        (i_src_w),
        .i_src_h        (i_src_h),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_address (o_word_address),
        .o_color        (o_color),
        .o_write_enable (o_write_enable),
        .o_last         (o_last),
        .o_idle         (o_idle)
    );

    scaled_blit_fill_engine_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_pixel          (i_pixel),
        .i_dest_x         (i_dest_x),
        .i_dest_y         (i_dest_y),
        .i_dest_w         (i_dest_w),
        .i_dest_h         (i_dest_h),
        .i_src_w          (i_src_w),
        .i_src_h          (i_src_h),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_word_address   (o_word_address),
        .i_color          (o_color),
        .i_write_enable   (o_write_enable),
        .i_last           (o_last),
        .i_idle           (o_idle),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // offer one transaction, with random gaps, and wait until it is taken
    task automatic send_item(t_op op, logic [PIX_W-1:0] pixel, int x, int y,
                             int w, int h, int sw, int sh);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_pixel    <= pixel;
        i_dest_x   <= x[COORD_W-1:0];
        i_dest_y   <= y[COORD_W-1:0];
        i_dest_w   <= w[DIM_W-1:0];
        i_dest_h   <= h[DIM_W-1:0];
        i_src_w    <= sw[DIM_W-1:0];
        i_src_h    <= sh[DIM_W-1:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // transaction whose unused fields carry random values; the source size is
    // either tiny or too large for the store, so a blit never reads past the
    // primed entries
    task automatic send_op(t_op op, logic [PIX_W-1:0] pixel);
        int sw, sh;
        sw = $urandom_range(4096, 0);
        sh = (sw <= 8) ? $urandom_range(8, 0) : $urandom_range(4096, 4096 / sw + 1);
        send_item(op, pixel, $urandom_range(16383, 0) - 8192, $urandom_range(16383, 0) - 8192,
                  $urandom_range(8191, 0), $urandom_range(8191, 0), sw, sh);
    endtask

    // wait until every expected result is in and the engine has settled
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(int width, int height, int pitch);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= width[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= height[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_ROW_PITCH;
        i_cfg_data  <= pitch[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        screen_w = width;
        screen_h = height;
    endtask

    // rectangle origin: near zero, just negative, around the clip edge, or anywhere
    function automatic int pick_coord(int edge_pos);
        case ($urandom_range(3, 0))
            0:       return $urandom_range(12, 0);
            1:       return -int'($urandom_range(4, 1));
            2:       return edge_pos - int'($urandom_range(4, 0));
            default: return int'($urandom_range(16383, 0)) - 8192;
        endcase
    endfunction

    // steps after a start: mostly the whole rectangle plus a few idle ones
    function automatic int step_budget(int cells);
        int capped;
        capped = (cells > 30) ? 30 : cells;
        if ($urandom_range(3, 0) == 0) return $urandom_range(capped, 1);
        return capped + $urandom_range(2, 0);
    endfunction

    // random traffic, mostly well-formed fill and blit sequences
    task automatic run_random(int count);
        int target, kind, w, h, sw, sh, loads;
        target = items_sent + count;
        while (items_sent < target) begin
            kind = $urandom_range(99, 0);
            if (kind < 35) begin
                // fill of a small rectangle
                w = $urandom_range(6, 1);
                h = $urandom_range(5, 1);
                send_item(OP_FILL, $urandom, pick_coord(screen_w), pick_coord(screen_h),
                          w, h, $urandom_range(4096, 0), $urandom_range(4096, 0));
                repeat (step_budget(w * h)) send_op(OP_STEP, $urandom);
            end else if (kind < 75) begin
                // fresh source pixels, then a scaled blit; a large source is
                // only sampled within its primed first entries
                w = $urandom_range(7, 1);
                h = $urandom_range(6, 1);
                case ($urandom_range(9, 0))
                    0:       begin sw = 64;   sh = 64;   h = 1; end
                    1:       begin sw = SOURCE_DEPTH; sh = 1; w = 1; end
                    2:       begin sw = 1;    sh = SOURCE_DEPTH; h = 1; end
                    default: begin sw = $urandom_range(8, 1); sh = $urandom_range(8, 1); end
                endcase
                loads = (sw * sh <= 16) ? sw * sh : $urandom_range(4, 0);
                repeat (loads) send_op(OP_LOAD, $urandom);
                send_item(OP_BLIT, $urandom, pick_coord(screen_w), pick_coord(screen_h),
                          w, h, sw, sh);
                repeat (step_budget(w * h)) send_op(OP_STEP, $urandom);
            end else if (kind < 85) begin
                // start with wild fields, a few steps
                send_op(($urandom_range(1, 0) != 0) ? OP_BLIT : OP_FILL, $urandom);
                repeat ($urandom_range(4, 1)) send_op(OP_STEP, $urandom);
            end else begin
                // single transaction of any kind
                send_op(t_op'($urandom_range(3, 0)), $urandom);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle step, a few loads, blit with a clipped column
        send_op(OP_STEP, $urandom);
        send_op(OP_LOAD, 32'hFFFF_FFFF);
        send_op(OP_LOAD, 32'h0000_0000);
        send_op(OP_LOAD, 32'hA5A5_A5A5);
        send_op(OP_LOAD, 32'h5A5A_5A5A);
        send_item(OP_BLIT, 32'h0, -1, 0, 3, 2, 2, 2);
        repeat (3) send_op(OP_STEP, $urandom);
        // fill started mid-blit, clipped top row and right edge, past the end
        send_item(OP_FILL, 32'hFFFF_FFFF, SCREEN_WIDTH_RST - 2, -1, 8191, 2, 0, 0);
        repeat (5) send_op(OP_STEP, $urandom);
        // empty operations: oversized source, zero sizes, off-screen rectangle
        send_item(OP_BLIT, 32'h0, 0, 0, 1, 1, SOURCE_DEPTH, 2);
        send_op(OP_STEP, $urandom);
        send_item(OP_FILL, 32'h1234_5678, 8191, 0, 0, 1, 0, 0);
        send_item(OP_FILL, 32'h1234_5678, -8192, 8191, 1, 1, 0, 0);
        send_item(OP_BLIT, 32'h0, 0, 0, 1, 1, 0, 1);
        send_op(OP_STEP, $urandom);
        // tall fill starting far above the screen
        send_item(OP_FILL, 32'h0, 0, -8192, 1, 8191, 0, 0);
        send_op(OP_STEP, $urandom);

        // prime the low end of the source store that every later blit reads
        repeat (PRIME_LOADS) send_op(OP_LOAD, $urandom);

        run_random(220);
        write_config(4096, 4096, 8192);
        run_random(170);

        // sender idles more than the receiver
        tx_idle_pct = 78;
        rx_idle_pct <= 36;
        write_config(1, 1, 1);
        run_random(90);
        write_config(37, 23, 100);
        run_random(220);

        // no idling, with one long output hold-off
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        write_config($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(8192, 1));
        run_random(60);
        hold_request <= 1'b1;
        run_random(200);

        wait_drained();
        if (mismatch_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
